// ===== hw/rtl/fbc_pkg.sv =====
package fbc_pkg;

  // plane storage
  localparam int PLANES  = 6;
  localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int COEFF_W = 32;

  // input tdata packing, lowest bit first
  localparam int IDX_W       = 3;
  localparam int IDX_LSB     = 0;
  localparam int COEFF_A_LSB = IDX_LSB + IDX_W;
  localparam int COEFF_B_LSB = COEFF_A_LSB + COEFF_W;
  localparam int COEFF_C_LSB = COEFF_B_LSB + COEFF_W;
  localparam int COEFF_D_LSB = COEFF_C_LSB + COEFF_W;
  localparam int CORNER_X_LSB = COEFF_D_LSB + COEFF_W;
  localparam int CORNER_Y_LSB = CORNER_X_LSB + COEFF_W;
  localparam int CORNER_Z_LSB = CORNER_Y_LSB + COEFF_W;
  localparam int IN_BITS     = CORNER_Z_LSB + COEFF_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  // multiply-accumulate widths: four full products need two guard bits
  localparam int PROD_W = 2 * COEFF_W;
  localparam int ACC_W  = PROD_W + 2;

  // the offset term is d * 1.0 in Q16.16
  localparam logic signed [COEFF_W-1:0] D_SCALE = 32'sh0001_0000;

  // command codes carried on tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_CORNER = 1'b1;

  typedef struct packed {
    logic signed [COEFF_W-1:0] d;
    logic signed [COEFF_W-1:0] c;
    logic signed [COEFF_W-1:0] b;
    logic signed [COEFF_W-1:0] a;
  } plane_row_t;

  // one multiply term issued to the shared unit
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [PLANE_W-1:0] plane;
  } mac_req_t;

  // plane distance sign coming back from the shared unit
  typedef struct packed {
    logic               done;
    logic [PLANE_W-1:0] plane;
    logic               negative;
  } mac_rsp_t;

endpackage

// ===== hw/rtl/fbc_plane_ram.sv =====
module fbc_plane_ram (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [fbc_pkg::PLANE_W-1:0]         wr_addr_i,
  input  fbc_pkg::plane_row_t                 wr_data_i,
  input  logic                                rd_en_i,
  input  logic [fbc_pkg::PLANE_W-1:0]         rd_addr_i,
  output fbc_pkg::plane_row_t                 rd_data_o
);
  import fbc_pkg::*;

  plane_row_t mem [PLANES];
  plane_row_t rd_data_q;

  // one row per plane, written by load requests
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/fbc_mac.sv =====
module fbc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbc_pkg::mac_req_t                   req_i,
  input  logic signed [fbc_pkg::COEFF_W-1:0]  op_a_i,
  input  logic signed [fbc_pkg::COEFF_W-1:0]  op_b_i,
  output fbc_pkg::mac_rsp_t                   rsp_o
);
  import fbc_pkg::*;

  logic                     vld_q;
  logic                     first_q;
  logic                     last_q;
  logic [PLANE_W-1:0]       plane_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic                     rsp_done_q;
  logic [PLANE_W-1:0]       rsp_plane_q;
  logic                     rsp_neg_q;

  // product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.valid;
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    first_q <= req_i.first;
    last_q  <= req_i.last;
    plane_q <= req_i.plane;
    prod_q  <= op_a_i * op_b_i;
  end

  // accumulate, restarting on the first term of a plane
  always_comb begin
    if (first_q) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      acc_q <= acc_d;
    end
  end

  // report the sign once the fourth term is in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_done_q <= 1'b0;
    end else begin
      rsp_done_q <= vld_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_plane_q <= plane_q;
    rsp_neg_q   <= acc_d[ACC_W-1];
  end

  assign rsp_o = '{done: rsp_done_q, plane: rsp_plane_q, negative: rsp_neg_q};

endmodule

// ===== hw/rtl/frustum_box_cull_core.sv =====
// frustum_box_cull_core: box versus view-frustum culling
//
// input stream (s_axis): tuser selects the request kind. a load request
// writes one plane's a, b, c, d coefficients; a plane index beyond the
// table is dropped. a corner request computes that corner's signed
// distance to every plane and sets the plane's inside or outside flag;
// tlast marks the box's final corner.
// output stream (m_axis): one request per final corner, tdata bit 0 is
// visible (0 when some plane has every corner outside).
//
// timing: a corner runs one multiply term per cycle through a single shared
// 32x32 multiplier, four terms per plane, so tready stays low while the
// corner goes through fetch, run and drain, and for a final corner through
// emit as well, where the result is posted once the output register is
// free. a load request leaves tready high.
// a waiting result sits in the output register while new requests are
// taken; if it is still waiting when the next box finishes, tready stays
// low until the receiver takes it.
// reset clears the flags and the output; planes must be loaded before use.
module frustum_box_cull_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // plane_index[2:0], coeff_a, coeff_b, coeff_c, coeff_d,
  // corner_x, corner_y, corner_z (32 bits each), zero fill
  input  logic [fbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command
  input  logic                               s_axis_tuser,
  // last_corner
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // visible, zero fill
  output logic [fbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import fbc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    TERM_A,
    TERM_B,
    TERM_C,
    TERM_D
  } term_e;

  state_e             state_q, state_d;
  term_e              term_q, term_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [PLANES-1:0]  inside_q, inside_d;
  logic [PLANES-1:0]  outside_q, outside_d;
  logic               m_valid_q, m_valid_d;
  logic               vis_q, vis_d;

  logic signed [COEFF_W-1:0] corner_x_q, corner_y_q, corner_z_q;
  logic                      last_q;

  logic [IDX_W-1:0]   in_idx;
  logic               s_accept;
  logic               last_plane;
  logic               out_free;
  logic               wr_en;
  logic               rd_en;
  logic [PLANE_W-1:0] rd_addr;
  plane_row_t         wr_row;
  plane_row_t         row;
  mac_req_t           mac_req;
  mac_rsp_t           mac_rsp;
  logic signed [COEFF_W-1:0] op_a, op_b;
  logic [PLANES-1:0]  hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[IDX_LSB +: IDX_W];
  assign last_plane    = (plane_q == PLANE_W'(PLANES - 1));
  assign out_free      = !m_valid_q || m_axis_tready;

  // plane load path
  assign wr_row.a = s_axis_tdata[COEFF_A_LSB +: COEFF_W];
  assign wr_row.b = s_axis_tdata[COEFF_B_LSB +: COEFF_W];
  assign wr_row.c = s_axis_tdata[COEFF_C_LSB +: COEFF_W];
  assign wr_row.d = s_axis_tdata[COEFF_D_LSB +: COEFF_W];
  assign wr_en    = s_accept && (s_axis_tuser == CMD_LOAD) && (int'(in_idx) < PLANES);

  // prefetch the next plane's row during the last term of the current one
  assign rd_en   = (state_q == ST_FETCH) ||
                   ((state_q == ST_RUN) && (term_q == TERM_D) && !last_plane);
  assign rd_addr = (state_q == ST_FETCH) ? '0 : plane_q + PLANE_W'(1);

  fbc_plane_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (PLANE_W'(in_idx)),
    .wr_data_i (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (row)
  );

  // corner capture
  always_ff @(posedge clk_i) begin
    if (s_accept && (s_axis_tuser == CMD_CORNER)) begin
      corner_x_q <= s_axis_tdata[CORNER_X_LSB +: COEFF_W];
      corner_y_q <= s_axis_tdata[CORNER_Y_LSB +: COEFF_W];
      corner_z_q <= s_axis_tdata[CORNER_Z_LSB +: COEFF_W];
      last_q     <= s_axis_tlast;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (term_q)
      TERM_A: begin
        op_a = row.a;
        op_b = corner_x_q;
      end
      TERM_B: begin
        op_a = row.b;
        op_b = corner_y_q;
      end
      TERM_C: begin
        op_a = row.c;
        op_b = corner_z_q;
      end
      TERM_D: begin
        op_a = row.d;
        op_b = D_SCALE;
      end
      default: begin
        op_a = row.a;
        op_b = corner_x_q;
      end
    endcase
  end

  assign mac_req.valid = (state_q == ST_RUN);
  assign mac_req.first = (term_q == TERM_A);
  assign mac_req.last  = (term_q == TERM_D);
  assign mac_req.plane = plane_q;

  fbc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .rsp_o  (mac_rsp)
  );

  // one-hot of the plane whose distance just came back
  always_comb begin
    for (int i = 0; i < PLANES; i++) begin
      hit[i] = mac_rsp.done && (mac_rsp.plane == PLANE_W'(i));
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    term_d    = term_q;
    plane_d   = plane_q;
    m_valid_d = m_valid_q;
    vis_d     = vis_q;
    inside_d  = inside_q;
    outside_d = outside_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (mac_rsp.negative) begin
      outside_d = outside_q | hit;
    end else begin
      inside_d = inside_q | hit;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept && (s_axis_tuser == CMD_CORNER)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_RUN;
        term_d  = TERM_A;
        plane_d = '0;
      end
      ST_RUN: begin
        term_d = term_e'(term_q + 2'd1);
        if (term_q == TERM_D) begin
          if (last_plane) begin
            state_d = ST_DRAIN;
          end else begin
            plane_d = plane_q + PLANE_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (mac_rsp.done && (mac_rsp.plane == PLANE_W'(PLANES - 1))) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          vis_d     = ((outside_q & ~inside_q) == '0);
          inside_d  = '0;
          outside_d = '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      term_q    <= TERM_A;
      plane_q   <= '0;
      inside_q  <= '0;
      outside_q <= '0;
      m_valid_q <= 1'b0;
      vis_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      term_q    <= term_d;
      plane_q   <= plane_d;
      inside_q  <= inside_d;
      outside_q <= outside_d;
      m_valid_q <= m_valid_d;
      vis_q     <= vis_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, vis_q};

`ifndef SYNTHESIS
  // distances only come back while a corner is in flight
  a_rsp_in_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.done |-> (state_q == ST_RUN) || (state_q == ST_DRAIN))
    else $error("plane distance returned outside a corner");

  // a new result is only raised by the emit step
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  // flags are clear for the next box once a result is posted
  a_flags_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_free) |=> (inside_q == '0) && (outside_q == '0))
    else $error("plane flags not cleared after result");

  // no request is taken while the multiplier is busy
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_req.valid |-> !s_axis_tready)
    else $error("input ready while corner in progress");
`endif

endmodule
